// File: hdl/mi3_pkg.sv
// ============================================================================
// mi3_pkg
// Shared widths, constants and bus types of the 3x3 matrix inverse pipeline.
// ============================================================================
package mi3_pkg;

   localparam int DATA_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int LANES   = 9;
   localparam int ROW_W   = 3;

   // A cofactor product, the cofactor and its magnitude.
   localparam int PROD_W  = 2 * DATA_W;
   localparam int COF_W   = PROD_W + 1;
   localparam int CMAG_W  = PROD_W;

   // Determinant partial products, terms and magnitude.
   localparam int PP_W    = 2 * DATA_W + 1;
   localparam int TERM_W  = PP_W + DATA_W;
   localparam int DMAG_W  = TERM_W - 1;

   // Divider remainder and quotient.
   localparam int REM_W   = DMAG_W + 1;
   localparam int QUO_W   = 2 * FRAC_W + 1;

   localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Cofactor k = e[A] * e[B] - e[C] * e[D], entries indexed row-major.
   localparam int COF_A [LANES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_B [LANES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_C [LANES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_D [LANES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   // Cofactors that pair with the first row in the determinant expansion.
   localparam int DET_COF [ROW_W] = '{0, 3, 6};

   typedef logic [LANES-1:0][DATA_W-1:0] mat_type;

   typedef struct packed {
      logic [ROW_W-1:0][DATA_W-1:0] row1;
      logic [LANES-1:0][COF_W-1:0]  cof;
   } cof_bus_type;

   typedef struct packed {
      logic [LANES-1:0][CMAG_W-1:0] cmag;
      logic [LANES-1:0]             neg;
      logic [LANES-1:0]             big;
      logic [DMAG_W-1:0]            dmag;
      logic                         dzero;
   } div_bus_type;

   typedef struct packed {
      logic [LANES-1:0][QUO_W-1:0] quo;
      logic [LANES-1:0]            neg;
      logic [LANES-1:0]            big;
      logic                        dzero;
   } quo_bus_type;

endpackage

// File: hdl/mi3_ifs.sv
// ============================================================================
// mi3_ifs
// Request and response channels of the matrix inverse block.
// ============================================================================
interface mi3_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mi3_pkg::DATA_W-1:0]   m11, m12, m13, m21, m22, m23, m31, m32, m33;

   modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                   input ready);
   modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                   output ready);
endinterface

interface mi3_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mi3_pkg::DATA_W-1:0]   r11, r12, r13, r21, r22, r23, r31, r32, r33;
   logic                                singular;
   logic                                overflow;

   modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                   singular, overflow, input ready);
   modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                   singular, overflow, output ready);
endinterface

// File: hdl/mi3_cof.sv
// ============================================================================
// mi3_cof
// Two stages: the eighteen 2x2 products, then the nine signed cofactors.
// ============================================================================
module mi3_cof (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mi3_pkg::mat_type     in_mat,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mi3_pkg::cof_bus_type out_bus
);

   logic [1:0] vld_ff;
   logic [1:0] adv;

   logic signed [mi3_pkg::PROD_W-1:0] pa_ff [mi3_pkg::LANES];
   logic signed [mi3_pkg::PROD_W-1:0] pb_ff [mi3_pkg::LANES];
   logic signed [mi3_pkg::PROD_W-1:0] pa_in [mi3_pkg::LANES];
   logic signed [mi3_pkg::PROD_W-1:0] pb_in [mi3_pkg::LANES];
   logic [mi3_pkg::ROW_W-1:0][mi3_pkg::DATA_W-1:0] row1_ff;
   mi3_pkg::cof_bus_type bus_ff;
   mi3_pkg::cof_bus_type bus_in;

   always_comb begin
      adv[1] = !vld_ff[1] || out_ready;
      adv[0] = !vld_ff[0] || adv[1];
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[1];
   assign out_bus   = bus_ff;

   always_comb begin
      for (int k = 0; k < mi3_pkg::LANES; k++) begin
         pa_in[k] = $signed(in_mat[mi3_pkg::COF_A[k]]) * $signed(in_mat[mi3_pkg::COF_B[k]]);
         pb_in[k] = $signed(in_mat[mi3_pkg::COF_C[k]]) * $signed(in_mat[mi3_pkg::COF_D[k]]);
      end
   end

   always_comb begin
      bus_in.row1 = row1_ff;
      for (int k = 0; k < mi3_pkg::LANES; k++) begin
         bus_in.cof[k] = {pa_ff[k][mi3_pkg::PROD_W-1], pa_ff[k]}
                       - {pb_ff[k][mi3_pkg::PROD_W-1], pb_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= in_valid;
         end
         if (adv[1]) begin
            vld_ff[1] <= vld_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         row1_ff <= in_mat[mi3_pkg::ROW_W-1:0];
      end
      if (adv[1]) begin
         bus_ff <= bus_in;
      end
   end

endmodule

// File: hdl/mi3_det.sv
// ============================================================================
// mi3_det
// Five stages: determinant partial products, terms, sum, magnitude, and the
// per-entry sign and quotient range check.
// ============================================================================
module mi3_det (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mi3_pkg::cof_bus_type in_bus,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mi3_pkg::div_bus_type out_bus
);

   localparam int NSTG = 5;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] adv;

   // Stage 1.
   logic signed [mi3_pkg::PP_W-1:0] pplo_ff [mi3_pkg::ROW_W];
   logic signed [mi3_pkg::PP_W-1:0] pphi_ff [mi3_pkg::ROW_W];
   logic signed [mi3_pkg::PP_W-1:0] pplo_in [mi3_pkg::ROW_W];
   logic signed [mi3_pkg::PP_W-1:0] pphi_in [mi3_pkg::ROW_W];
   logic [mi3_pkg::LANES-1:0][mi3_pkg::CMAG_W-1:0] cmag1_ff, cmag1_in;
   logic [mi3_pkg::LANES-1:0] csign1_ff, csign1_in;
   // Stage 2.
   logic [mi3_pkg::TERM_W-1:0] term_ff [mi3_pkg::ROW_W];
   logic [mi3_pkg::TERM_W-1:0] term_in [mi3_pkg::ROW_W];
   logic [mi3_pkg::LANES-1:0][mi3_pkg::CMAG_W-1:0] cmag2_ff;
   logic [mi3_pkg::LANES-1:0] csign2_ff;
   // Stage 3.
   logic [mi3_pkg::TERM_W-1:0] det_ff, det_in;
   logic [mi3_pkg::LANES-1:0][mi3_pkg::CMAG_W-1:0] cmag3_ff;
   logic [mi3_pkg::LANES-1:0] csign3_ff;
   // Stage 4.
   logic [mi3_pkg::DMAG_W-1:0] dmag_ff, dmag_in;
   logic dsign_ff, dzero_ff;
   logic [mi3_pkg::TERM_W-1:0] det_neg;
   logic [mi3_pkg::LANES-1:0][mi3_pkg::CMAG_W-1:0] cmag4_ff;
   logic [mi3_pkg::LANES-1:0] csign4_ff;
   // Stage 5.
   mi3_pkg::div_bus_type bus_ff, bus_in;

   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || out_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_bus   = bus_ff;

   // Each 65-bit cofactor splits into a signed high half and an unsigned low
   // half so that every product stays near 32 by 32 bits.
   always_comb begin
      logic [mi3_pkg::COF_W-1:0] c;
      logic [mi3_pkg::COF_W-1:0] c_neg;
      for (int j = 0; j < mi3_pkg::ROW_W; j++) begin
         c = in_bus.cof[mi3_pkg::DET_COF[j]];
         pplo_in[j] = $signed(in_bus.row1[j]) * $signed({1'b0, c[mi3_pkg::DATA_W-1:0]});
         pphi_in[j] = $signed(in_bus.row1[j])
                    * $signed(c[mi3_pkg::COF_W-1:mi3_pkg::DATA_W]);
      end
      for (int k = 0; k < mi3_pkg::LANES; k++) begin
         c            = in_bus.cof[k];
         c_neg        = -c;
         csign1_in[k] = c[mi3_pkg::COF_W-1];
         cmag1_in[k]  = c[mi3_pkg::COF_W-1] ? c_neg[mi3_pkg::CMAG_W-1:0]
                                            : c[mi3_pkg::CMAG_W-1:0];
      end
   end

   always_comb begin
      for (int j = 0; j < mi3_pkg::ROW_W; j++) begin
         term_in[j] = {pphi_ff[j], {mi3_pkg::DATA_W{1'b0}}}
                    + {{mi3_pkg::DATA_W{pplo_ff[j][mi3_pkg::PP_W-1]}}, pplo_ff[j]};
      end
   end

   assign det_in  = term_ff[0] + term_ff[1] + term_ff[2];
   assign det_neg = -det_ff;
   assign dmag_in = det_ff[mi3_pkg::TERM_W-1] ? det_neg[mi3_pkg::DMAG_W-1:0]
                                              : det_ff[mi3_pkg::DMAG_W-1:0];

   // An entry is out of range when its quotient reaches 2^QUO_W, which is
   // the case exactly when the cofactor is at least twice the determinant.
   always_comb begin
      bus_in.cmag  = cmag4_ff;
      bus_in.dmag  = dmag_ff;
      bus_in.dzero = dzero_ff;
      for (int k = 0; k < mi3_pkg::LANES; k++) begin
         bus_in.neg[k] = csign4_ff[k] ^ dsign_ff;
         bus_in.big[k] = {{(mi3_pkg::REM_W-mi3_pkg::CMAG_W){1'b0}}, cmag4_ff[k]}
                         >= {dmag_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pplo_ff   <= pplo_in;
         pphi_ff   <= pphi_in;
         cmag1_ff  <= cmag1_in;
         csign1_ff <= csign1_in;
      end
      if (adv[1]) begin
         term_ff   <= term_in;
         cmag2_ff  <= cmag1_ff;
         csign2_ff <= csign1_ff;
      end
      if (adv[2]) begin
         det_ff    <= det_in;
         cmag3_ff  <= cmag2_ff;
         csign3_ff <= csign2_ff;
      end
      if (adv[3]) begin
         dmag_ff   <= dmag_in;
         dsign_ff  <= det_ff[mi3_pkg::TERM_W-1];
         dzero_ff  <= (det_ff == '0);
         cmag4_ff  <= cmag3_ff;
         csign4_ff <= csign3_ff;
      end
      if (adv[4]) begin
         bus_ff <= bus_in;
      end
   end

endmodule

// File: hdl/mi3_div.sv
// ============================================================================
// mi3_div
// Pipelined restoring divider, one quotient bit per stage for nine lanes.
// ============================================================================
module mi3_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mi3_pkg::div_bus_type in_bus,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mi3_pkg::quo_bus_type out_bus
);

   localparam int NSTG = mi3_pkg::QUO_W;

   typedef struct packed {
      logic [mi3_pkg::LANES-1:0][mi3_pkg::REM_W-1:0] rem;
      logic [mi3_pkg::LANES-1:0][mi3_pkg::QUO_W-1:0] quo;
      logic [mi3_pkg::LANES-1:0]                     neg;
      logic [mi3_pkg::LANES-1:0]                     big;
      logic [mi3_pkg::DMAG_W-1:0]                    dmag;
      logic                                          dzero;
   } stg_type;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] adv;
   stg_type         stg_ff [NSTG];
   stg_type         stg_in [NSTG];

   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || out_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[NSTG-1];

   // The first stage divides the cofactor itself (top quotient bit); each
   // later stage doubles the remainder and tries one more subtraction.
   always_comb begin
      stg_type                    base;
      logic [mi3_pkg::REM_W-1:0]  trial;
      logic                       ge;
      for (int s = 0; s < NSTG; s++) begin
         if (s == 0) begin
            base.neg   = in_bus.neg;
            base.big   = in_bus.big;
            base.dmag  = in_bus.dmag;
            base.dzero = in_bus.dzero;
            for (int l = 0; l < mi3_pkg::LANES; l++) begin
               base.rem[l] = {{(mi3_pkg::REM_W-mi3_pkg::CMAG_W){1'b0}}, in_bus.cmag[l]};
               base.quo[l] = '0;
            end
         end else begin
            base = stg_ff[s-1];
         end
         stg_in[s] = base;
         for (int l = 0; l < mi3_pkg::LANES; l++) begin
            trial = (s == 0) ? base.rem[l] : {base.rem[l][mi3_pkg::REM_W-2:0], 1'b0};
            ge    = trial >= {1'b0, base.dmag};
            stg_in[s].rem[l] = ge ? trial - {1'b0, base.dmag} : trial;
            stg_in[s].quo[l] = {base.quo[l][mi3_pkg::QUO_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (adv[i]) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   assign out_bus.quo   = stg_ff[NSTG-1].quo;
   assign out_bus.neg   = stg_ff[NSTG-1].neg;
   assign out_bus.big   = stg_ff[NSTG-1].big;
   assign out_bus.dzero = stg_ff[NSTG-1].dzero;

endmodule

// File: hdl/mat3_inverse.sv
// ============================================================================
// mat3_inverse
// Inverse of a 3x3 signed Q16.16 matrix through the adjugate.
// ============================================================================
// Each request carries a matrix in row-major order and produces one response
// with the nine inverse entries, exact quotients truncated toward zero and
// saturated to Q16.16, plus a singular flag (zero determinant, all entries
// zero) and an overflow flag (some entry saturated). The block accepts one
// request per clock unless back-pressure stalls it, and returns responses
// in order. Two stages form the cofactors, five form the determinant, 33
// produce one quotient bit each in the nine-lane divider, and one saturates
// into the response register. Back-pressure from the response side stalls
// only the occupied stages, so empty slots in the pipeline are squeezed out
// before the request side sees ready go low.
// ============================================================================
module mat3_inverse (
   input  logic          clock,
   input  logic          reset,
   mi3_req_if.sink       req_ch,
   mi3_rsp_if.source     rsp_ch
);

   mi3_pkg::mat_type     in_mat;
   mi3_pkg::cof_bus_type cof_bus;
   mi3_pkg::div_bus_type div_bus;
   mi3_pkg::quo_bus_type quo_bus;

   logic cof_valid, cof_ready;
   logic div_valid, div_ready;
   logic quo_valid, quo_ready;

   logic                                          out_vld_ff;
   logic [mi3_pkg::LANES-1:0][mi3_pkg::DATA_W-1:0] res_ff, res_in;
   logic                                          sing_ff, sing_in;
   logic                                          ovf_ff, ovf_in;

   assign in_mat[0] = req_ch.m11;
   assign in_mat[1] = req_ch.m12;
   assign in_mat[2] = req_ch.m13;
   assign in_mat[3] = req_ch.m21;
   assign in_mat[4] = req_ch.m22;
   assign in_mat[5] = req_ch.m23;
   assign in_mat[6] = req_ch.m31;
   assign in_mat[7] = req_ch.m32;
   assign in_mat[8] = req_ch.m33;

   mi3_cof u_cof (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_mat    (in_mat),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .out_bus   (cof_bus)
   );

   mi3_det u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .in_bus    (cof_bus),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_bus   (div_bus)
   );

   mi3_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_bus    (div_bus),
      .out_valid (quo_valid),
      .out_ready (quo_ready),
      .out_bus   (quo_bus)
   );

   // The response register takes a new result whenever it is empty or its
   // current result is being taken in this cycle.
   assign quo_ready = !out_vld_ff || rsp_ch.ready;

   // Saturation. A positive quotient must stay below 2^31; a negative one may
   // reach 2^31 exactly, which is the most negative word. The range flag from
   // the determinant stage covers quotients too large for the divider.
   always_comb begin
      logic [mi3_pkg::QUO_W-1:0] q;
      logic [mi3_pkg::QUO_W-1:0] q_neg;
      sing_in = quo_bus.dzero;
      ovf_in  = 1'b0;
      for (int l = 0; l < mi3_pkg::LANES; l++) begin
         q     = quo_bus.quo[l];
         q_neg = -q;
         if (quo_bus.dzero) begin
            res_in[l] = '0;
         end else if (!quo_bus.neg[l]) begin
            if (quo_bus.big[l] || (q[mi3_pkg::QUO_W-1:mi3_pkg::DATA_W-1] != '0)) begin
               res_in[l] = mi3_pkg::WORD_MAX;
               ovf_in    = 1'b1;
            end else begin
               res_in[l] = q[mi3_pkg::DATA_W-1:0];
            end
         end else begin
            if (quo_bus.big[l]
                || (q > {{(mi3_pkg::QUO_W-mi3_pkg::DATA_W){1'b0}}, mi3_pkg::WORD_MIN})) begin
               res_in[l] = mi3_pkg::WORD_MIN;
               ovf_in    = 1'b1;
            end else begin
               res_in[l] = q_neg[mi3_pkg::DATA_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (quo_ready) begin
         out_vld_ff <= quo_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (quo_ready) begin
         res_ff  <= res_in;
         sing_ff <= sing_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_ch.valid    = out_vld_ff;
   assign rsp_ch.r11      = res_ff[0];
   assign rsp_ch.r12      = res_ff[1];
   assign rsp_ch.r13      = res_ff[2];
   assign rsp_ch.r21      = res_ff[3];
   assign rsp_ch.r22      = res_ff[4];
   assign rsp_ch.r23      = res_ff[5];
   assign rsp_ch.r31      = res_ff[6];
   assign rsp_ch.r32      = res_ff[7];
   assign rsp_ch.r33      = res_ff[8];
   assign rsp_ch.singular = sing_ff;
   assign rsp_ch.overflow = ovf_ff;

   // A singular response carries zeros and never reports saturation.
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.singular |-> !rsp_ch.overflow && (res_ff == '0))
      else $error("singular response with nonzero payload");

   // The ready chain runs through every stage: a ready response side means
   // every stage can move, so the request side must be ready too.
   a_ready_chain : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("request side stalled while response side is ready");

   // Reset empties the response register.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

endmodule
